// ===== rtl/ole_pkg.sv =====
// Shared constants, codes and control types for the ordered list engine.
package ole_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;

    typedef logic [1:0] t_op;
    localparam t_op OP_ADD_FRONT = 2'd0;
    localparam t_op OP_ADD_BACK  = 2'd1;
    localparam t_op OP_REMOVE    = 2'd2;
    localparam t_op OP_LIST      = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status ST_DONE     = 3'd0;
    localparam t_status ST_ENTRY    = 3'd1;
    localparam t_status ST_EMPTY    = 3'd2;
    localparam t_status ST_FULL     = 3'd3;
    localparam t_status ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic load_in;
        logic do_exec;
        logic do_list;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic out_free;
        logic occ_zero;
        logic list_end;
    } t_sts;

endpackage

// ===== rtl/ole_ctrl.sv =====
// Sequencer for the ordered list engine: accept, execute, list.
module ole_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ole_pkg::t_sts i_sts,
    output ole_pkg::t_cmd o_cmd
);
    import ole_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.load_in = 1'b0;
        o_cmd.do_exec = 1'b0;
        o_cmd.do_list = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    if (i_sts.op == OP_LIST && !i_sts.occ_zero) begin
                        o_cmd.do_list = 1'b1;
                        n_state       = i_sts.list_end ? S_IDLE : S_LIST;
                    end else begin
                        o_cmd.do_exec = 1'b1;
                        n_state       = S_IDLE;
                    end
                end
            end
            S_LIST: begin
                if (i_sts.out_free) begin
                    o_cmd.do_list = 1'b1;
                    if (i_sts.list_end) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/ole_datapath.sv =====
// Shifting entry table, occupancy, list cursor and result register.
module ole_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ole_pkg::t_cmd                 i_cmd,
    input  ole_pkg::t_op                  i_op,
    input  logic signed [ole_pkg::VAL_W-1:0] i_value,
    output ole_pkg::t_sts                 o_sts,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [ole_pkg::VAL_W-1:0] o_item,
    output ole_pkg::t_status              o_status,
    output logic                          o_last
);
    import ole_pkg::*;

    logic signed [VAL_W-1:0] r_cell [CAPACITY];
    logic [OCC_W-1:0]        r_occ;
    logic [IDX_W-1:0]        r_cnt;
    t_op                     r_op;
    logic signed [VAL_W-1:0] r_value;

    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_item;
    t_status                 r_status;
    logic                    r_last;

    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] first_hit;
    logic [CAPACITY-1:0] shift_left;
    logic                found;
    logic                full;
    logic                list_end;

    // Every cell compares against the search value at once.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = (OCC_W'(i) < r_occ) && (r_cell[i] == r_value);
        end
    end

    assign first_hit  = match & (~match + CAPACITY'(1));
    assign shift_left = ~(first_hit - CAPACITY'(1));
    assign found      = |match;
    assign full       = (r_occ == OCC_W'(CAPACITY));
    assign list_end   = ({1'b0, r_cnt} == OCC_W'(r_occ - OCC_W'(1)));

    assign o_sts.op       = r_op;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.occ_zero = (r_occ == '0);
    assign o_sts.list_end = list_end;

    // Input capture and list cursor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_cnt   <= '0;
        end else if (i_cmd.do_list) begin
            r_cnt <= r_cnt + IDX_W'(1);
        end
    end

    // Add front shifts right, add back appends, remove pulls left from the hit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_exec) begin
            case (r_op)
                OP_ADD_FRONT: begin
                    if (!full) begin
                        for (int i = CAPACITY - 1; i > 0; i--) begin
                            r_cell[i] <= r_cell[i-1];
                        end
                        r_cell[0] <= r_value;
                    end
                end
                OP_ADD_BACK: begin
                    if (!full) r_cell[r_occ[IDX_W-1:0]] <= r_value;
                end
                OP_REMOVE: begin
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (found && shift_left[i]) r_cell[i] <= r_cell[i+1];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.do_exec) begin
            case (r_op) inside
                OP_ADD_FRONT, OP_ADD_BACK: if (!full) r_occ <= r_occ + OCC_W'(1);
                OP_REMOVE:                 if (found) r_occ <= r_occ - OCC_W'(1);
                default: ;
            endcase
        end
    end

    // Result register: hold until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.do_exec || i_cmd.do_list) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_list) begin
            r_item   <= r_cell[r_cnt];
            r_status <= ST_ENTRY;
            r_last   <= list_end;
        end else if (i_cmd.do_exec) begin
            r_item <= '0;
            r_last <= 1'b1;
            case (r_op) inside
                OP_ADD_FRONT, OP_ADD_BACK: r_status <= full ? ST_FULL : ST_DONE;
                OP_REMOVE:                 r_status <= found ? ST_DONE : ST_NOTFOUND;
                default:                   r_status <= ST_EMPTY;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_item      = r_item;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

// ===== rtl/ordered_list_engine_unit.sv =====
// A request is captured into the input registers in the idle state; its first result is
// registered in the execute state once the output register is free. Add and remove give
// one result each; list gives one per entry or an empty status; back pressure stalls it.
// A request is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) empties the list and the output; no clearing pass.
// Top level of the ordered list engine: controller plus table datapath.
module ordered_list_engine_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [31:0]                 i_s_axis_tdata,  // [31:0] value
    input  logic [1:0]                  i_s_axis_tuser,  // [1:0] op
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [31:0]                 o_m_axis_tdata,  // [31:0] item
    output logic [2:0]                  o_m_axis_tuser,  // [2:0] status
    output logic                        o_m_axis_tlast
);
    import ole_pkg::*;

    t_cmd                    cmd;
    t_sts                    sts;
    logic signed [VAL_W-1:0] item;
    t_status                 status;

    ole_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ole_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (i_s_axis_tuser),
        .i_value     (signed'(i_s_axis_tdata)),
        .o_sts       (sts),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_item      (item),
        .o_status    (status),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = unsigned'(item);
    assign o_m_axis_tuser = status;

endmodule

// ===== dv/ordered_list_engine_unit_tb.sv =====
// Self-checking testbench for the ordered list engine: directed and random requests.
module ordered_list_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ole_pkg::*;

    localparam int LONG_HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES     = 8;

    typedef struct {
        logic [31:0] item;
        t_status     status;
        logic        last;
    } t_list_result;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_value = '0;
    t_op         s_op    = OP_ADD_FRONT;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // Predicted list contents, front at index 0, and results still owed by the block.
    logic [31:0]  list_model[$];
    t_list_result pending_results[$];

    logic idle_on      = 1'b1;
    int   hold_request = 0;
    int   hold_seen    = 0;
    int   hold_left    = 0;
    int   stall_left   = 0;

    int n_errors   = 0;
    int n_requests = 0;
    int n_results  = 0;
    int n_full     = 0;
    int n_notfound = 0;
    int n_listed   = 0;

    ordered_list_engine_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_value),         // [31:0] value
        .i_s_axis_tuser  (s_op),            // [1:0] op
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [31:0] item
        .o_m_axis_tuser  (o_m_axis_tuser),  // [2:0] status
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void push_result(logic [31:0] item, t_status status, logic last);
        t_list_result r;
        r.item   = item;
        r.status = status;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_request(t_op op, logic [31:0] value);
        int hit;
        hit = -1;
        case (op)
            OP_ADD_FRONT, OP_ADD_BACK: begin
                if (list_model.size() >= CAPACITY) begin
                    push_result('0, ST_FULL, 1'b1);
                    n_full++;
                end else begin
                    if (op == OP_ADD_FRONT) list_model.push_front(value);
                    else list_model.push_back(value);
                    push_result('0, ST_DONE, 1'b1);
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < list_model.size(); i++) begin
                    if (hit < 0 && list_model[i] == value) hit = i;
                end
                if (hit >= 0) begin
                    list_model.delete(hit);
                    push_result('0, ST_DONE, 1'b1);
                end else begin
                    push_result('0, ST_NOTFOUND, 1'b1);
                    n_notfound++;
                end
            end
            default: begin
                if (list_model.size() == 0) begin
                    push_result('0, ST_EMPTY, 1'b1);
                end else begin
                    foreach (list_model[i])
                        push_result(list_model[i], ST_ENTRY, i == list_model.size() - 1);
                    n_listed += list_model.size();
                end
            end
        endcase
    endfunction

    // Called at a rising edge; returns at the edge after the transaction and any gap.
    task automatic send_request(input t_op op, input logic [31:0] value);
        int gap;
        s_valid <= 1'b1;
        s_op    <= op;
        s_value <= value;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_request(op, value);
        n_requests++;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_op    <= t_op'($urandom_range(0, 3));
            s_value <= $urandom();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver: random stalls, plus a long hold whenever a test asks for one.
    always @(posedge i_clk) begin
        if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (idle_on) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: item %h status %0d last %b",
                       o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata !== want.item) begin
                    $error("item: expected %h, got %h", want.item, o_m_axis_tdata);
                    n_errors++;
                end
                if (o_m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_axis_tuser);
                    n_errors++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_m_axis_tlast);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_empty_list();
        send_request(OP_LIST, $urandom());
        send_request(OP_REMOVE, 32'h0000_0000);
        send_request(OP_REMOVE, 32'h8000_0000);
    endtask

    task automatic test_insert_and_list();
        send_request(OP_ADD_FRONT, 32'h7FFF_FFFF);
        send_request(OP_ADD_FRONT, 32'h8000_0000);
        send_request(OP_ADD_BACK,  32'h0000_0000);
        send_request(OP_ADD_BACK,  32'hFFFF_FFFF);
        send_request(OP_ADD_BACK,  32'h7FFF_FFFF);
        send_request(OP_LIST, $urandom());
    endtask

    // Covers a miss, the first of two duplicates, front, middle and back removal.
    task automatic test_remove_cases();
        send_request(OP_REMOVE, 32'h1234_5678);
        send_request(OP_REMOVE, 32'h7FFF_FFFF);
        send_request(OP_LIST, $urandom());
        send_request(OP_REMOVE, 32'h8000_0000);
        send_request(OP_REMOVE, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 32'h7FFF_FFFF);
        send_request(OP_REMOVE, 32'h0000_0000);
        send_request(OP_LIST, $urandom());
    endtask

    // Hold the receiver off while the sender keeps offering, so the input stalls.
    task automatic test_output_backpressure();
        idle_on      <= 1'b0;
        hold_request <= hold_request + 1;
        for (int i = 0; i < 6; i++) send_request(OP_ADD_BACK, $urandom());
        send_request(OP_LIST, $urandom());
        send_request(OP_ADD_FRONT, $urandom());
        send_request(OP_LIST, $urandom());
        send_request(OP_REMOVE, $urandom());
        idle_on <= 1'b1;
    endtask

    task automatic test_full_list();
        while (list_model.size() < CAPACITY) begin
            send_request($urandom_range(0, 1) ? OP_ADD_FRONT : OP_ADD_BACK, $urandom());
        end
        send_request(OP_ADD_FRONT, $urandom());
        send_request(OP_ADD_BACK, $urandom());
        send_request(OP_LIST, $urandom());
        send_request(OP_REMOVE, list_model[CAPACITY - 1]);
        send_request(OP_ADD_FRONT, 32'h8000_0000);
        send_request(OP_ADD_BACK, $urandom());
        send_request(OP_LIST, $urandom());
        // drain most of the list, alternating front and back entries
        while (list_model.size() > 4) begin
            send_request(OP_REMOVE, list_model.size() % 2 ? list_model[0]
                                                          : list_model[list_model.size() - 1]);
        end
    endtask

    task automatic test_random_traffic(input int count);
        int          r;
        t_op         op;
        logic [31:0] value;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) idle_on <= ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            // lean toward adds when the list is short so it sweeps up to full
            if (r < (list_model.size() < 20 ? 32 : 22)) op = OP_ADD_FRONT;
            else if (r < (list_model.size() < 20 ? 64 : 44)) op = OP_ADD_BACK;
            else if (r < 88) op = OP_REMOVE;
            else op = OP_LIST;
            r = $urandom_range(0, 99);
            if (op == OP_REMOVE && list_model.size() != 0 && r < 65)
                value = list_model[$urandom_range(0, list_model.size() - 1)];
            else if (r < 80)
                value = $urandom();
            else
                value = 32'($signed($urandom_range(0, 6)) - 3);
            send_request(op, value);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_insert_and_list();
        test_remove_cases();
        test_output_backpressure();
        test_full_list();
        test_random_traffic(180);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d requests sent, %0d results checked (%0d listed entries)",
                 n_requests, n_results, n_listed);
        $display("%0d inserts dropped on a full list, %0d removals missed, %0d errors",
                 n_full, n_notfound, n_errors);
        if (n_errors == 0) begin
            $display("ordered_list_engine_unit verification clean");
        end else begin
            $display("ordered_list_engine_unit verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("ordered_list_engine_unit verification failed");
        $finish;
    end

endmodule
